[rtl/wwlm_pkg.sv]
package wwlm_pkg;

  localparam int unsigned MaxWordBytes = 16;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned WordLenW     = 5;
  localparam int unsigned CntW         = 32;
  localparam int unsigned OutDataW     = 104;

  localparam logic [7:0]      NewlineByte = 8'h0A;
  localparam logic [CntW-1:0] CntMax      = '1;

  // default separator classes: everything except digits and ascii letters
  localparam logic [63:0] SepMap0Rst = 64'hFC00_FFFF_FFFF_FFFF;
  localparam logic [63:0] SepMap1Rst = 64'hF800_0001_F800_0001;
  localparam logic [63:0] SepMap2Rst = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SepMap3Rst = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WordLenW-1:0] WordLenRst   = 5'd1;
  localparam logic [CntW-1:0]     LineLimitRst = 32'd1024;

  typedef enum logic [CfgIdxW-1:0] {
    RegSepMap0   = 3'd0,
    RegSepMap1   = 3'd1,
    RegSepMap2   = 3'd2,
    RegSepMap3   = 3'd3,
    RegWordLow   = 3'd4,
    RegWordHigh  = 3'd5,
    RegWordLen   = 3'd6,
    RegLineLimit = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhScan   = 2'd0,
    PhMatch  = 2'd1,
    PhFinish = 2'd2
  } phase_e;

  typedef struct packed {
    logic            too_long;
    logic [CntW-1:0] line_length;
    logic [CntW-1:0] line_start_offset;
    logic [CntW-1:0] line_num;
  } res_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    return (v == CntMax) ? CntMax : v + CntW'(1);
  endfunction

endpackage

[rtl/wwlm_cfg.sv]
module wwlm_cfg #(
  parameter int unsigned MAX_WORD_BYTES = wwlm_pkg::MaxWordBytes
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wwlm_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [wwlm_pkg::CfgDataW-1:0]         cfg_wdata_i,
  output logic [255:0]                          sep_map_o,
  output logic [MAX_WORD_BYTES*8-1:0]           word_o,
  output logic [wwlm_pkg::WordLenW-1:0]         word_len_o,
  output logic [wwlm_pkg::CntW-1:0]             line_limit_o
);

  logic [255:0]                        sep_q, sep_d;
  logic [MAX_WORD_BYTES*8-1:0]         word_q, word_d;
  logic [wwlm_pkg::WordLenW-1:0]       len_q, len_d;
  logic [wwlm_pkg::CntW-1:0]           limit_q, limit_d;
  wwlm_pkg::cfg_idx_e                  idx;

  assign idx = wwlm_pkg::cfg_idx_e'(cfg_idx_i);

  always_comb begin
    sep_d   = sep_q;
    word_d  = word_q;
    len_d   = len_q;
    limit_d = limit_q;
    if (cfg_we_i) begin
      case (idx)
        wwlm_pkg::RegSepMap0:   sep_d[63:0]    = cfg_wdata_i;
        wwlm_pkg::RegSepMap1:   sep_d[127:64]  = cfg_wdata_i;
        wwlm_pkg::RegSepMap2:   sep_d[191:128] = cfg_wdata_i;
        wwlm_pkg::RegSepMap3:   sep_d[255:192] = cfg_wdata_i;
        wwlm_pkg::RegWordLen:   len_d   = cfg_wdata_i[wwlm_pkg::WordLenW-1:0];
        wwlm_pkg::RegLineLimit: limit_d = cfg_wdata_i[wwlm_pkg::CntW-1:0];
        default: ;
      endcase
      // only the bytes that fit the word store are kept
      for (int k = 0; k < MAX_WORD_BYTES; k++) begin
        if (k < 8) begin
          if (idx == wwlm_pkg::RegWordLow) word_d[8*k +: 8] = cfg_wdata_i[8*k +: 8];
        end else begin
          if (idx == wwlm_pkg::RegWordHigh) word_d[8*k +: 8] = cfg_wdata_i[8*(k-8) +: 8];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= {wwlm_pkg::SepMap3Rst, wwlm_pkg::SepMap2Rst,
                  wwlm_pkg::SepMap1Rst, wwlm_pkg::SepMap0Rst};
      word_q  <= '0;
      len_q   <= wwlm_pkg::WordLenRst;
      limit_q <= wwlm_pkg::LineLimitRst;
    end else begin
      sep_q   <= sep_d;
      word_q  <= word_d;
      len_q   <= len_d;
      limit_q <= limit_d;
    end
  end

  // effective word length, clamped to one .. store depth
  always_comb begin
    if (len_q == '0) begin
      word_len_o = wwlm_pkg::WordLenW'(1);
    end else if (len_q > wwlm_pkg::WordLenW'(MAX_WORD_BYTES)) begin
      word_len_o = wwlm_pkg::WordLenW'(MAX_WORD_BYTES);
    end else begin
      word_len_o = len_q;
    end
  end

  assign sep_map_o    = sep_q;
  assign word_o       = word_q;
  assign line_limit_o = limit_q;

endmodule

[rtl/wwlm_step.sv]
module wwlm_step #(
  parameter int unsigned MAX_WORD_BYTES = wwlm_pkg::MaxWordBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [7:0]                    data_byte_i,
  input  logic                          last_byte_i,
  input  logic [255:0]                  sep_map_i,
  input  logic [MAX_WORD_BYTES*8-1:0]   word_i,
  input  logic [wwlm_pkg::WordLenW-1:0] word_len_i,
  input  logic [wwlm_pkg::CntW-1:0]     line_limit_i,
  output logic                          res_valid_o,
  output wwlm_pkg::res_t                res_o
);

  localparam int unsigned ProgW = $clog2(MAX_WORD_BYTES + 1);
  localparam int unsigned IdxW  = (MAX_WORD_BYTES > 1) ? $clog2(MAX_WORD_BYTES) : 1;
  localparam int unsigned CntW  = wwlm_pkg::CntW;

  logic [CntW-1:0]   line_q, line_d, begin_q, begin_d, pos_q, pos_d;
  logic              ws_q, ws_d;
  logic [ProgW-1:0]  prog_q, prog_d;
  wwlm_pkg::phase_e  phase_q, phase_d;

  logic              is_sep, is_nl, word_full, word_full_next;
  logic              do_next, emit_nl, emit_eof;
  logic [7:0]        word_cur;
  logic [IdxW-1:0]   word_idx;
  logic [CntW+1:0]   len_end, len_diff;
  logic [CntW-1:0]   len_sat;

  assign is_sep         = sep_map_i[data_byte_i];
  assign is_nl          = (data_byte_i == wwlm_pkg::NewlineByte);
  assign word_idx       = IdxW'(prog_q);
  assign word_cur       = word_i[8*word_idx +: 8];
  assign word_full      = (wwlm_pkg::WordLenW'(prog_q) >= word_len_i);
  assign word_full_next = (phase_d == wwlm_pkg::PhMatch) &&
                          (wwlm_pkg::WordLenW'(prog_d) >= word_len_i);

  always_comb begin
    phase_d = phase_q;
    prog_d  = prog_q;
    ws_d    = ws_q;
    line_d  = line_q;
    begin_d = begin_q;
    do_next = 1'b0;
    emit_nl = 1'b0;
    case (phase_q)
      wwlm_pkg::PhScan: begin
        if (is_nl) begin
          do_next = 1'b1;
        end else if (ws_q && data_byte_i == word_i[7:0]) begin
          prog_d  = ProgW'(1);
          phase_d = wwlm_pkg::PhMatch;
        end else begin
          ws_d = is_sep;
        end
      end
      wwlm_pkg::PhMatch: begin
        if (!word_full) begin
          // word bytes win over the newline test
          if (data_byte_i == word_cur) begin
            prog_d = prog_q + ProgW'(1);
          end else if (is_nl) begin
            do_next = 1'b1;
          end else begin
            ws_d    = is_sep;
            prog_d  = '0;
            phase_d = wwlm_pkg::PhScan;
          end
        end else if (is_sep) begin
          prog_d  = '0;
          phase_d = wwlm_pkg::PhFinish;
          if (is_nl) begin
            emit_nl = 1'b1;
            do_next = 1'b1;
          end
        end else if (is_nl) begin
          do_next = 1'b1;
        end else begin
          ws_d    = 1'b0;
          prog_d  = '0;
          phase_d = wwlm_pkg::PhScan;
        end
      end
      default: begin
        if (is_nl) begin
          emit_nl = 1'b1;
          do_next = 1'b1;
        end
      end
    endcase
    if (do_next) begin
      line_d  = wwlm_pkg::sat_inc(line_q);
      begin_d = wwlm_pkg::sat_inc(pos_q);
      ws_d    = 1'b1;
      prog_d  = '0;
      phase_d = wwlm_pkg::PhScan;
    end
  end

  // a matched line still open at end of file is reported including its last byte
  assign emit_eof = last_byte_i && !emit_nl &&
                    (phase_d == wwlm_pkg::PhFinish || word_full_next ||
                     (phase_d != wwlm_pkg::PhScan && phase_d != wwlm_pkg::PhMatch));

  assign len_end  = {2'b00, pos_q} + (CntW+2)'(emit_eof);
  assign len_diff = len_end - {2'b00, begin_q};
  assign len_sat  = (len_diff[CntW+1:CntW] != 2'b00) ? wwlm_pkg::CntMax
                                                     : len_diff[CntW-1:0];

  assign res_valid_o             = emit_nl || emit_eof;
  assign res_o.line_num          = line_q;
  assign res_o.line_start_offset = begin_q;
  assign res_o.line_length       = len_sat;
  assign res_o.too_long          = (len_sat > line_limit_i);

  assign pos_d = wwlm_pkg::sat_inc(pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q  <= CntW'(1);
      begin_q <= '0;
      pos_q   <= '0;
      ws_q    <= 1'b1;
      prog_q  <= '0;
      phase_q <= wwlm_pkg::PhScan;
    end else if (en_i) begin
      if (last_byte_i) begin
        line_q  <= CntW'(1);
        begin_q <= '0;
        pos_q   <= '0;
        ws_q    <= 1'b1;
        prog_q  <= '0;
        phase_q <= wwlm_pkg::PhScan;
      end else begin
        line_q  <= line_d;
        begin_q <= begin_d;
        pos_q   <= pos_d;
        ws_q    <= ws_d;
        prog_q  <= prog_d;
        phase_q <= phase_d;
      end
    end
  end

endmodule

[rtl/whole_word_line_matcher.sv]
// channel  | handshake                         | payload
// s_axis   | s_axis_tvalid / s_axis_tready     | tdata: data_byte, tlast: last_byte
// m_axis   | m_axis_tvalid / m_axis_tready     | tdata: line_num, line_start_offset,
//          |                                   |        line_length, too_long
// cfg      | cfg_we_i (no back-pressure)       | cfg_idx_i, cfg_wdata_i
//
// one byte per cycle sustained while the result register is not stalled: a byte is
// held in the input register, the scan step and the length/limit compare run between
// it and the result register, from which the result transaction is offered
// reset clears scan state and loads the default separator classes, word and limit
// a stalled result register holds the step; an empty input register takes one more byte
module whole_word_line_matcher #(
  parameter int unsigned MAX_WORD_BYTES = wwlm_pkg::MaxWordBytes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // byte stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] data_byte
  input  logic                              s_axis_tlast,  // last_byte
  // matching lines out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] line_num, [63:32] line_start_offset, [95:64] line_length,
  // [96] too_long, [103:97] zero
  output logic [wwlm_pkg::OutDataW-1:0]     m_axis_tdata,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [wwlm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wwlm_pkg::CfgDataW-1:0]     cfg_wdata_i
);

  localparam int unsigned ResW = $bits(wwlm_pkg::res_t);

  logic [255:0]                      sep_map;
  logic [MAX_WORD_BYTES*8-1:0]       word;
  logic [wwlm_pkg::WordLenW-1:0]     word_len;
  logic [wwlm_pkg::CntW-1:0]         line_limit;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       in_accept, advance;

  // result register
  logic            out_valid_q;
  wwlm_pkg::res_t  out_res_q;
  logic            step_valid;
  wwlm_pkg::res_t  step_res;

  wwlm_cfg #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sep_map_o   (sep_map),
    .word_o      (word),
    .word_len_o  (word_len),
    .line_limit_o(line_limit)
  );

  // the step retires only while the result register is empty or drains this cycle
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  wwlm_step #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (advance),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .sep_map_i   (sep_map),
    .word_i      (word),
    .word_len_i  (word_len),
    .line_limit_i(line_limit),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && step_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && step_valid) begin
      out_res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(wwlm_pkg::OutDataW - ResW)'(0), out_res_q};

endmodule

[rtl/wwlm_checker.sv]
module wwlm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [wwlm_pkg::OutDataW-1:0] m_axis_tdata
);

  // a stalled result keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // an empty result register never blocks the byte stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // line numbers are one-based
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[31:0] != 32'd0)
    else $error("line number zero reported");

  // too_long needs a non-empty line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[96] |-> m_axis_tdata[95:64] != 32'd0)
    else $error("too_long set on empty line");

  // padding bits stay clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[103:97] == 7'd0)
    else $error("padding bits set in result");

endmodule

bind whole_word_line_matcher wwlm_checker u_wwlm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
